// ===== hw/rtl/wss_pkg.sv =====
package wss_pkg;

    localparam int MAX_WAYPOINTS = 64;
    localparam int IDX_W = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    localparam logic [6:0] MUL_STEPS  = 7'd33;
    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd34;

    localparam logic [1:0] MODE_FOLLOW = 2'd1;
    localparam logic [1:0] MODE_FLEE   = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_SPEED  = 3'd1;
    localparam logic [2:0] REG_RADIUS = 3'd2;
    localparam logic [2:0] REG_FLEE_X = 3'd3;
    localparam logic [2:0] REG_FLEE_Y = 3'd4;
    localparam logic [2:0] REG_FLEE_Z = 3'd5;

    localparam logic REQ_LOAD = 1'b0;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage

// ===== hw/rtl/waypoint_steering_step.sv =====
// Load items are accepted one per cycle while no step is in progress and give no result.
// In idle mode a step needs only the move; flee mode adds a distance pass and the velocity, and
// follow mode up to two passes and the slowdown; a new item is accepted once the result is registered.
// Multiply, divide and root share one bit-serial unit; path entries are undefined after reset.
// One item is processed at a time; a finished result waits while the output register is stalled.
// Reset clears count, index, mode, flee point, valid and reached flags; presets speed and radius.
module waypoint_steering_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic               new_path,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [15:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] next_x,
    output logic signed [31:0] next_y,
    output logic signed [31:0] next_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z,
    output logic               waypoint_hit,
    output logic [5:0]         hit_index,
    output logic [5:0]         current_index,
    output logic               target_reached,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import wss_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RD      = 5'd1;
    localparam logic [4:0] S_DIFF    = 5'd2;
    localparam logic [4:0] S_SQ_GO   = 5'd3;
    localparam logic [4:0] S_SQ_WAIT = 5'd4;
    localparam logic [4:0] S_RT_GO   = 5'd5;
    localparam logic [4:0] S_RT_WAIT = 5'd6;
    localparam logic [4:0] S_SM_GO   = 5'd7;
    localparam logic [4:0] S_SM_WAIT = 5'd8;
    localparam logic [4:0] S_SD_GO   = 5'd9;
    localparam logic [4:0] S_SD_WAIT = 5'd10;
    localparam logic [4:0] S_VM_GO   = 5'd11;
    localparam logic [4:0] S_VM_WAIT = 5'd12;
    localparam logic [4:0] S_VD_GO   = 5'd13;
    localparam logic [4:0] S_VD_WAIT = 5'd14;
    localparam logic [4:0] S_MV_GO   = 5'd15;
    localparam logic [4:0] S_MV_WAIT = 5'd16;
    localparam logic [4:0] S_EMIT    = 5'd17;

    logic [4:0]       state_reg, state_next;
    logic [1:0]       comp_reg, comp_next;
    logic             pass2_reg, pass2_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] follow_reg, follow_next;
    logic             reached_reg, reached_next;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]         mode_reg;
    logic [30:0]        speed_cfg_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] flee_reg [3];

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic [15:0]        dt_reg, dt_next;
    logic signed [32:0] d_reg [3];
    logic signed [32:0] d_next [3];
    logic [65:0]        sum_reg, sum_next;
    logic [33:0]        len_reg, len_next;
    logic [30:0]        speed_reg, speed_next;
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] vel_next [3];
    logic signed [31:0] nxt_reg [3];
    logic signed [31:0] nxt_next [3];
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;

    logic signed [31:0] o_pos_reg [3];
    logic signed [31:0] o_pos_next [3];
    logic signed [31:0] o_vel_reg [3];
    logic signed [31:0] o_vel_next [3];
    logic               o_hit_reg, o_hit_next;
    logic [5:0]         o_hit_idx_reg, o_hit_idx_next;
    logic [5:0]         o_cur_reg, o_cur_next;
    logic               o_reached_reg, o_reached_next;

    logic [95:0]      path_mem [MAX_WAYPOINTS];
    logic [95:0]      rd_data_reg;
    logic             accept;
    logic [CNT_W-1:0] eff_count;
    logic             load_we;
    logic [32:0]      lim;
    logic [33:0]      rlen;
    logic [CNT_W-1:0] follow_inc;
    logic [31:0]      mv_mag;
    logic signed [33:0] mv_sum;
    logic signed [31:0] wp [3];
    logic             cfg_we;

    unit_ctl_t   ctl;
    unit_stat_t  ustat;
    logic [65:0] opa;
    logic [35:0] opb;
    logic [65:0] result;

    wss_serial_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .opa    (opa),
        .opb    (opb),
        .stat   (ustat),
        .result (result)
    );

    assign in_stall  = (state_reg != S_IDLE) || ustat.busy;
    assign accept    = in_valid && !in_stall;
    assign eff_count = new_path ? '0 : count_reg;
    assign load_we   = accept && (req_type == REQ_LOAD) &&
                       (eff_count < CNT_W'(MAX_WAYPOINTS));
    assign lim        = {2'b0, radius_reg} + {1'b0, radius_reg, 1'b0};
    assign rlen       = result[33:0];
    assign follow_inc = CNT_W'(follow_reg) + CNT_W'(1);
    assign mv_mag     = result[47:16];
    assign wp[0]      = rd_data_reg[95:64];
    assign wp[1]      = rd_data_reg[63:32];
    assign wp[2]      = rd_data_reg[31:0];
    assign mv_sum     = vel_reg[comp_reg][31]
                        ? {{2{pos_reg[comp_reg][31]}}, pos_reg[comp_reg]} - {2'b0, mv_mag}
                        : {{2{pos_reg[comp_reg][31]}}, pos_reg[comp_reg]} + {2'b0, mv_mag};

    always_comb
    begin
        ctl.start = 1'b0;
        ctl.op    = OP_MUL;
        opa       = '0;
        opb       = '0;
        case (state_reg)
            S_SQ_GO:
            begin
                ctl.start = 1'b1;
                opa = {33'b0, mag33(d_reg[comp_reg])};
                opb = {3'b0, mag33(d_reg[comp_reg])};
            end
            S_RT_GO:
            begin
                ctl.start = 1'b1;
                ctl.op    = OP_SQRT;
                opa       = sum_reg;
            end
            S_SM_GO:
            begin
                ctl.start = 1'b1;
                opa = {35'b0, speed_cfg_reg};
                opb = {3'b0, len_reg[32:0]};
            end
            S_SD_GO:
            begin
                ctl.start = 1'b1;
                ctl.op    = OP_DIV;
                opa       = sum_reg;
                opb       = {3'b0, lim};
            end
            S_VM_GO:
            begin
                ctl.start = 1'b1;
                opa = {33'b0, mag33(d_reg[comp_reg])};
                opb = {5'b0, speed_reg};
            end
            S_VD_GO:
            begin
                ctl.start = 1'b1;
                ctl.op    = OP_DIV;
                opa       = sum_reg;
                opb       = {2'b0, len_reg};
            end
            S_MV_GO:
            begin
                ctl.start = 1'b1;
                opa = {33'b0, mag33({vel_reg[comp_reg][31], vel_reg[comp_reg]})};
                opb = {20'b0, dt_reg};
            end
            default:
            begin
                ctl.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        comp_next      = comp_reg;
        pass2_next     = pass2_reg;
        count_next     = count_reg;
        follow_next    = follow_reg;
        reached_next   = reached_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        dt_next        = dt_reg;
        d_next         = d_reg;
        sum_next       = sum_reg;
        len_next       = len_reg;
        speed_next     = speed_reg;
        vel_next       = vel_reg;
        nxt_next       = nxt_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        o_pos_next     = o_pos_reg;
        o_vel_next     = o_vel_reg;
        o_hit_next     = o_hit_reg;
        o_hit_idx_next = o_hit_idx_reg;
        o_cur_next     = o_cur_reg;
        o_reached_next = o_reached_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_LOAD))
                begin
                    if (new_path)
                    begin
                        follow_next  = '0;
                        reached_next = 1'b0;
                    end
                    count_next = load_we ? eff_count + CNT_W'(1) : eff_count;
                end
                else if (accept)
                begin
                    pos_next[0]  = coord_x;
                    pos_next[1]  = coord_y;
                    pos_next[2]  = coord_z;
                    dt_next      = time_step;
                    hit_next     = 1'b0;
                    hit_idx_next = '0;
                    pass2_next   = 1'b0;
                    comp_next    = 2'd0;
                    sum_next     = '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        vel_next[i] = '0;
                    end
                    if (mode_reg == MODE_FOLLOW)
                    begin
                        if (count_reg == '0)
                        begin
                            reached_next = 1'b1;
                            state_next   = S_MV_GO;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    else if (mode_reg == MODE_FLEE)
                    begin
                        d_next[0]  = {coord_x[31], coord_x} - {flee_reg[0][31], flee_reg[0]};
                        d_next[1]  = {coord_y[31], coord_y} - {flee_reg[1][31], flee_reg[1]};
                        d_next[2]  = {coord_z[31], coord_z} - {flee_reg[2][31], flee_reg[2]};
                        state_next = S_SQ_GO;
                    end
                    else
                    begin
                        state_next = S_MV_GO;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_next[i] = {wp[i][31], wp[i]} - {pos_reg[i][31], pos_reg[i]};
                end
                sum_next   = '0;
                comp_next  = 2'd0;
                state_next = S_SQ_GO;
            end
            S_SQ_GO:
            begin
                state_next = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (ustat.done)
                begin
                    sum_next = sum_reg + result;
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = 2'd0;
                        state_next = S_RT_GO;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_SQ_GO;
                    end
                end
            end
            S_RT_GO:
            begin
                state_next = S_RT_WAIT;
            end
            S_RT_WAIT:
            begin
                if (ustat.done)
                begin
                    len_next = rlen;
                    if ((mode_reg == MODE_FOLLOW) && !pass2_reg && (rlen < {3'b0, radius_reg}))
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = follow_reg;
                        if (follow_inc < count_reg)
                        begin
                            follow_next = follow_reg + IDX_W'(1);
                            pass2_next  = 1'b1;
                            state_next  = S_RD;
                        end
                        else
                        begin
                            reached_next = 1'b1;
                            state_next   = S_MV_GO;
                        end
                    end
                    else if ((mode_reg == MODE_FOLLOW) && (lim != '0) && (rlen < {1'b0, lim}))
                    begin
                        state_next = S_SM_GO;
                    end
                    else
                    begin
                        speed_next = speed_cfg_reg;
                        state_next = (rlen == '0) ? S_MV_GO : S_VM_GO;
                    end
                end
            end
            S_SM_GO:
            begin
                state_next = S_SM_WAIT;
            end
            S_SM_WAIT:
            begin
                if (ustat.done)
                begin
                    sum_next   = result;
                    state_next = S_SD_GO;
                end
            end
            S_SD_GO:
            begin
                state_next = S_SD_WAIT;
            end
            S_SD_WAIT:
            begin
                if (ustat.done)
                begin
                    speed_next = result[30:0];
                    comp_next  = 2'd0;
                    state_next = (len_reg == '0) ? S_MV_GO : S_VM_GO;
                end
            end
            S_VM_GO:
            begin
                state_next = S_VM_WAIT;
            end
            S_VM_WAIT:
            begin
                if (ustat.done)
                begin
                    sum_next   = result;
                    state_next = S_VD_GO;
                end
            end
            S_VD_GO:
            begin
                state_next = S_VD_WAIT;
            end
            S_VD_WAIT:
            begin
                if (ustat.done)
                begin
                    vel_next[comp_reg] = d_reg[comp_reg][32] ? -$signed(result[31:0])
                                                             : $signed(result[31:0]);
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = 2'd0;
                        state_next = S_MV_GO;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_VM_GO;
                    end
                end
            end
            S_MV_GO:
            begin
                state_next = S_MV_WAIT;
            end
            S_MV_WAIT:
            begin
                if (ustat.done)
                begin
                    if (mv_sum[33] && (mv_sum[32:31] != 2'b11))
                    begin
                        nxt_next[comp_reg] = 32'sh8000_0000;
                    end
                    else if (!mv_sum[33] && (mv_sum[32:31] != 2'b00))
                    begin
                        nxt_next[comp_reg] = 32'sh7fff_ffff;
                    end
                    else
                    begin
                        nxt_next[comp_reg] = mv_sum[31:0];
                    end
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = 2'd0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_MV_GO;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_pos_next     = nxt_reg;
                    o_vel_next     = vel_reg;
                    o_hit_next     = hit_reg;
                    o_hit_idx_next = 6'(hit_idx_reg);
                    o_cur_next     = 6'(follow_reg);
                    o_reached_next = reached_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            comp_reg      <= 2'd0;
            pass2_reg     <= 1'b0;
            count_reg     <= '0;
            follow_reg    <= '0;
            reached_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 2'd0;
            speed_cfg_reg <= 31'd327680;
            radius_reg    <= 31'd32768;
            flee_reg[0]   <= '0;
            flee_reg[1]   <= '0;
            flee_reg[2]   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            pass2_reg     <= pass2_next;
            count_reg     <= count_next;
            follow_reg    <= follow_next;
            reached_reg   <= reached_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (paddr[4:2])
                    REG_MODE:   mode_reg      <= pwdata[1:0];
                    REG_SPEED:  speed_cfg_reg <= pwdata[30:0];
                    REG_RADIUS: radius_reg    <= pwdata[30:0];
                    REG_FLEE_X: flee_reg[0]   <= pwdata;
                    REG_FLEE_Y: flee_reg[1]   <= pwdata;
                    REG_FLEE_Z: flee_reg[2]   <= pwdata;
                    default:    mode_reg      <= mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        dt_reg        <= dt_next;
        d_reg         <= d_next;
        sum_reg       <= sum_next;
        len_reg       <= len_next;
        speed_reg     <= speed_next;
        vel_reg       <= vel_next;
        nxt_reg       <= nxt_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        o_pos_reg     <= o_pos_next;
        o_vel_reg     <= o_vel_next;
        o_hit_reg     <= o_hit_next;
        o_hit_idx_reg <= o_hit_idx_next;
        o_cur_reg     <= o_cur_next;
        o_reached_reg <= o_reached_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            path_mem[eff_count[IDX_W-1:0]] <= {coord_x, coord_y, coord_z};
        end
        rd_data_reg <= path_mem[follow_reg];
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MODE:   prdata = {30'b0, mode_reg};
            REG_SPEED:  prdata = {1'b0, speed_cfg_reg};
            REG_RADIUS: prdata = {1'b0, radius_reg};
            REG_FLEE_X: prdata = flee_reg[0];
            REG_FLEE_Y: prdata = flee_reg[1];
            REG_FLEE_Z: prdata = flee_reg[2];
            default:    prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign out_valid      = out_valid_reg;
    assign next_x         = o_pos_reg[0];
    assign next_y         = o_pos_reg[1];
    assign next_z         = o_pos_reg[2];
    assign vel_x          = o_vel_reg[0];
    assign vel_y          = o_vel_reg[1];
    assign vel_z          = o_vel_reg[2];
    assign waypoint_hit   = o_hit_reg;
    assign hit_index      = o_hit_idx_reg;
    assign current_index  = o_cur_reg;
    assign target_reached = o_reached_reg;

endmodule

// ===== hw/rtl/wss_serial_unit.sv =====
module wss_serial_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  wss_pkg::unit_ctl_t ctl,
    input  logic [65:0]        opa,
    input  logic [35:0]        opb,
    output wss_pkg::unit_stat_t stat,
    output logic [65:0]        result
);
    import wss_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [1:0]  op_reg, op_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [67:0] acc_reg, acc_next;
    logic [65:0] mcand_reg, mcand_next;
    logic [35:0] mplier_reg, mplier_next;
    logic [37:0] rem_reg, rem_next;
    logic [37:0] r2;
    logic [37:0] trial;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        r2          = '0;
        trial       = '0;
        if (ctl.start)
        begin
            busy_next   = 1'b1;
            op_next     = ctl.op;
            rem_next    = '0;
            mcand_next  = opa;
            mplier_next = opb;
            case (ctl.op)
                OP_DIV:
                begin
                    acc_next = {4'b0, opa[63:0]};
                    cnt_next = DIV_STEPS;
                end
                OP_SQRT:
                begin
                    acc_next    = {2'b0, opa};
                    mplier_next = '0;
                    cnt_next    = SQRT_STEPS;
                end
                default:
                begin
                    acc_next = '0;
                    cnt_next = MUL_STEPS;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_DIV:
                begin
                    r2 = {rem_reg[36:0], acc_reg[63]};
                    if (r2 >= {2'b0, mplier_reg})
                    begin
                        rem_next = r2 - {2'b0, mplier_reg};
                        acc_next = {4'b0, acc_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = r2;
                        acc_next = {4'b0, acc_reg[62:0], 1'b0};
                    end
                end
                OP_SQRT:
                begin
                    r2    = {rem_reg[35:0], acc_reg[67:66]};
                    trial = {mplier_reg, 2'b01};
                    if (r2 >= trial)
                    begin
                        rem_next    = r2 - trial;
                        mplier_next = {mplier_reg[34:0], 1'b1};
                    end
                    else
                    begin
                        rem_next    = r2;
                        mplier_next = {mplier_reg[34:0], 1'b0};
                    end
                    acc_next = {acc_reg[65:0], 2'b00};
                end
                default:
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + {2'b0, mcand_reg};
                    end
                    mcand_next  = {mcand_reg[64:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[35:1]};
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
    end

    always_comb
    begin
        case (op_reg)
            OP_DIV:  result = {2'b0, acc_reg[63:0]};
            OP_SQRT: result = {30'b0, mplier_reg};
            default: result = acc_reg[65:0];
        endcase
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
